[design/hcf_pkg.sv]
package hcf_pkg;

    localparam int FRAC_BITS_DEF = 36;
    localparam int GAIN_FRAC     = 8;
    localparam int MUL_LAT       = 2;

    localparam int STIFF_W = 20;
    localparam int DAMP_W  = 16;
    localparam int FORCE_W = 47;

    localparam logic [FORCE_W-1:0] FORCE_MAX = '1;

    localparam int CFG_IW = 8;
    localparam int CFG_DW = 32;

    localparam logic [CFG_IW-1:0] CFG_STIFF = 8'd0;
    localparam logic [CFG_IW-1:0] CFG_DAMP  = 8'd1;

    localparam logic [STIFF_W-1:0] STIFF_RST = 20'd256000;
    localparam logic [DAMP_W-1:0]  DAMP_RST  = 16'd2560;

endpackage

[design/hcf_mul.sv]
module hcf_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic              i_clk,
    input  logic [AW-1:0]     i_a,
    input  logic [BW-1:0]     i_b,
    output logic [AW+BW-1:0]  o_p
);

    logic [63:0]      a64;
    logic [63:0]      b64;
    logic [63:0]      r_ll;
    logic [63:0]      r_lh;
    logic [63:0]      r_hl;
    logic [63:0]      r_hh;
    logic [127:0]     n_sum;
    logic [AW+BW-1:0] r_p;

    assign a64 = 64'(i_a);
    assign b64 = 64'(i_b);

    // First stage forms four 32x32 partial products, second stage adds them.
    always_ff @(posedge i_clk) begin
        r_ll <= a64[31:0]  * b64[31:0];
        r_lh <= a64[31:0]  * b64[63:32];
        r_hl <= a64[63:32] * b64[31:0];
        r_hh <= a64[63:32] * b64[63:32];
    end

    assign n_sum = 128'(r_ll) + (128'(r_lh) << 32) + (128'(r_hl) << 32) + (128'(r_hh) << 64);

    always_ff @(posedge i_clk) begin
        r_p <= n_sum[AW+BW-1:0];
    end

    assign o_p = r_p;

endmodule

[design/hcf_div.sv]
module hcf_div #(
    parameter int NW = 74,
    parameter int DW = 38,
    parameter int QW = 37
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    // One quotient bit per stage. The caller guarantees i_num >> QW < i_den.
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_q   [QW];
    logic [DW-1:0] r_den [QW];

    genvar k;
    for (k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] p_rem;
        logic [DW-1:0] p_den;
        logic [QW-1:0] p_low;
        logic [QW-1:0] p_q;
        logic [DW:0]   n_try;
        logic          n_ge;

        if (k == 0) begin : g_first
            assign p_rem = DW'(i_num[NW-1:QW]);
            assign p_low = i_num[QW-1:0];
            assign p_q   = '0;
            assign p_den = i_den;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_low = r_low[k-1];
            assign p_q   = r_q[k-1];
            assign p_den = r_den[k-1];
        end

        assign n_try = {p_rem, p_low[QW-1]};
        assign n_ge  = n_try >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_ge ? DW'(n_try - {1'b0, p_den}) : n_try[DW-1:0];
            r_low[k] <= {p_low[QW-2:0], 1'b0};
            r_q[k]   <= {p_q[QW-2:0], n_ge};
            r_den[k] <= p_den;
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

[design/hcf_sqrt.sv]
module hcf_sqrt #(
    parameter int IW = 98
) (
    input  logic            i_clk,
    input  logic [IW-1:0]   i_x,
    output logic [IW/2-1:0] o_root
);

    localparam int OW = IW / 2;
    localparam int RW = OW + 2;

    // Digit-by-digit square root, one result bit per stage.
    logic [RW-1:0] r_rem  [OW];
    logic [OW-1:0] r_root [OW];
    logic [IW-1:0] r_x    [OW];

    genvar k;
    for (k = 0; k < OW; k++) begin : g_stage
        logic [RW-1:0] p_rem;
        logic [OW-1:0] p_root;
        logic [IW-1:0] p_x;
        logic [RW-1:0] n_try;
        logic [RW-1:0] n_sub;
        logic          n_ge;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_x    = i_x;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_x    = r_x[k-1];
        end

        assign n_try = {p_rem[RW-3:0], p_x[IW-1:IW-2]};
        assign n_sub = {p_root, 2'b01};
        assign n_ge  = n_try >= n_sub;

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_ge ? (n_try - n_sub) : n_try;
            r_root[k] <= {p_root[OW-2:0], n_ge};
            r_x[k]    <= {p_x[IW-3:0], 2'b00};
        end
    end

    assign o_root = r_root[OW-1];

endmodule

[design/hcf_dly.sv]
module hcf_dly #(
    parameter int W = 1,
    parameter int L = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    if (L == 0) begin : g_none
        assign o_q = i_d;
    end else begin : g_taps
        logic [W-1:0] r_tap [L];

        always_ff @(posedge i_clk) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < L; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end

        assign o_q = r_tap[L-1];
    end

endmodule

[design/hertzian_contact_force_top.sv]
// Hertzian contact force kernel for pairs of 2-D bodies. A pair is taken at any clock edge with
// start high (busy stays low, the pipeline never holds off), one pair per cycle, and its result
// appears on the output ports for one cycle with o_valid high. The latency is set by the
// bit-per-stage square root of the squared distance, the normal division and the damping
// product that follows it. The receiver cannot stall, so results must be taken when o_valid is
// high. Configuration writes are always accepted and should only be made while no pair is in
// flight.
module hertzian_contact_force_top import hcf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [47:0]        i_first_pos_x,
    input  logic signed [47:0]        i_first_pos_y,
    input  logic signed [47:0]        i_second_pos_x,
    input  logic signed [47:0]        i_second_pos_y,
    input  logic signed [44:0]        i_first_vel_x,
    input  logic signed [44:0]        i_first_vel_y,
    input  logic signed [44:0]        i_second_vel_x,
    input  logic signed [44:0]        i_second_vel_y,
    input  logic        [36:0]        i_first_radius,
    input  logic        [36:0]        i_second_radius,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic        [CFG_IW-1:0]  i_cfg_index,
    input  logic        [CFG_DW-1:0]  i_cfg_data,
    output logic                      o_valid,
    output logic                      o_in_contact,
    output logic signed [47:0]        o_force_x,
    output logic signed [47:0]        o_force_y,
    output logic        [37:0]        o_penetration,
    output logic signed [37:0]        o_normal_x,
    output logic signed [37:0]        o_normal_y,
    output logic        [46:0]        o_impulse_size
);

    localparam int F    = FRAC_BITS;
    localparam int DXW  = 49;
    localparam int DVW  = 46;
    localparam int RW   = 37;
    localparam int SW   = 38;
    localparam int D2W  = 2 * DXW;
    localparam int DSTW = D2W / 2;
    localparam int NQW  = F + 1;
    localparam int NMW  = 38;
    localparam int OFW  = 48;

    localparam int SRIW = RW + F + ((RW + F) % 2);
    localparam int SROW = SRIW / 2;
    localparam int KSW  = STIFF_W + SROW;
    localparam int SPIW = SW + F + ((SW + F) % 2);
    localparam int SPOW = SPIW / 2;
    localparam int PPW  = SW + SPOW;
    localparam int P15W = PPW - F;
    localparam int EPW  = KSW + P15W;
    localparam int ELW  = EPW - F - GAIN_FRAC;
    localparam int TW   = DVW + NQW;
    localparam int DTW  = TW + 2;
    localparam int VSW  = DTW - F;
    localparam int DPW  = DAMP_W + FORCE_W;
    localparam int DSW  = DPW - GAIN_FRAC;
    localparam int FPW  = FORCE_W + NQW;

    localparam int T_S1   = 1;
    localparam int T_PR   = T_S1 + MUL_LAT;
    localparam int T_D2   = T_PR + 1;
    localparam int T_DIST = T_D2 + DSTW;
    localparam int T_PEN  = T_DIST + 1;
    localparam int T_NRM  = T_DIST + NQW;
    localparam int T_REFF = T_PR + RW;
    localparam int T_SR   = T_REFF + SROW;
    localparam int T_KS   = T_SR + MUL_LAT;
    localparam int T_SP   = T_PEN + SPOW;
    localparam int T_P15  = T_SP + MUL_LAT;
    localparam int T_EPR  = T_P15 + MUL_LAT;
    localparam int T_EL   = T_EPR + 1;
    localparam int T_DT   = T_NRM + MUL_LAT;
    localparam int T_DOT  = T_DT + 1;
    localparam int T_VN   = T_DOT + 1;
    localparam int T_DPR  = T_VN + MUL_LAT;
    localparam int T_DMP  = T_DPR + 1;
    localparam int T_JN   = (T_EL > T_DMP) ? T_EL : T_DMP;
    localparam int T_FM   = T_JN + 1;
    localparam int T_FP   = T_FM + MUL_LAT;
    localparam int T_OUT  = T_FP + 1;

    // Configuration registers.
    logic [STIFF_W-1:0] r_stiff;
    logic [DAMP_W-1:0]  r_damp;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= STIFF_RST;
            r_damp  <= DAMP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_STIFF) begin
                r_stiff <= i_cfg_data[STIFF_W-1:0];
            end else if (i_cfg_index == CFG_DAMP) begin
                r_damp <= i_cfg_data[DAMP_W-1:0];
            end
        end
    end

    // Valid bits travel alongside the pipeline.
    logic [T_OUT:0] r_vld;
    logic [T_OUT:0] n_vld;

    assign n_vld = {r_vld[T_OUT-1:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage 0: differences and radius sum.
    logic [DXW-1:0] r_dx, r_dy;
    logic [DVW-1:0] r_dvx, r_dvy;
    logic [RW-1:0]  r_r1, r_r2;
    logic [SW-1:0]  r_s0;

    always_ff @(posedge i_clk) begin
        r_dx  <= 49'(i_second_pos_x) - 49'(i_first_pos_x);
        r_dy  <= 49'(i_second_pos_y) - 49'(i_first_pos_y);
        r_dvx <= 46'(i_second_vel_x) - 46'(i_first_vel_x);
        r_dvy <= 46'(i_second_vel_y) - 46'(i_first_vel_y);
        r_r1  <= i_first_radius;
        r_r2  <= i_second_radius;
        r_s0  <= SW'(i_first_radius) + SW'(i_second_radius);
    end

    // Stage 1: magnitudes and signs.
    logic [DXW-1:0] r_adx, r_ady;
    logic [DVW-1:0] r_advx, r_advy;
    logic [1:0]     r_sgn, r_flip;
    logic [RW-1:0]  r_r1b, r_r2b;
    logic [SW-1:0]  r_s1;

    always_ff @(posedge i_clk) begin
        r_adx  <= r_dx[DXW-1]  ? DXW'(~r_dx + 1'b1)  : r_dx;
        r_ady  <= r_dy[DXW-1]  ? DXW'(~r_dy + 1'b1)  : r_dy;
        r_advx <= r_dvx[DVW-1] ? DVW'(~r_dvx + 1'b1) : r_dvx;
        r_advy <= r_dvy[DVW-1] ? DVW'(~r_dvy + 1'b1) : r_dvy;
        r_sgn  <= {r_dx[DXW-1], r_dy[DXW-1]};
        r_flip <= {r_dvx[DVW-1] ^ r_dx[DXW-1], r_dvy[DVW-1] ^ r_dy[DXW-1]};
        r_r1b  <= r_r1;
        r_r2b  <= r_r2;
        r_s1   <= r_s0;
    end

    // Squares and radius products.
    logic [D2W-1:0]  xx, yy;
    logic [2*SW-1:0] ss;
    logic [2*RW-1:0] rr;

    hcf_mul #(.AW(DXW), .BW(DXW)) u_mul_xx (.i_clk, .i_a(r_adx), .i_b(r_adx), .o_p(xx));
    hcf_mul #(.AW(DXW), .BW(DXW)) u_mul_yy (.i_clk, .i_a(r_ady), .i_b(r_ady), .o_p(yy));
    hcf_mul #(.AW(SW),  .BW(SW))  u_mul_ss (.i_clk, .i_a(r_s1),  .i_b(r_s1),  .o_p(ss));
    hcf_mul #(.AW(RW),  .BW(RW))  u_mul_rr (.i_clk, .i_a(r_r1b), .i_b(r_r2b), .o_p(rr));

    logic [SW-1:0] s_pr;

    hcf_dly #(.W(SW), .L(T_PR - T_S1)) u_dly_spr (.i_clk, .i_d(r_s1), .o_q(s_pr));

    // Squared distance and the contact test on squares.
    logic [D2W-1:0] n_d2, r_d2;
    logic           r_con;

    assign n_d2 = xx + yy;

    always_ff @(posedge i_clk) begin
        r_d2  <= n_d2;
        r_con <= (n_d2 != '0) && (n_d2 < D2W'(ss));
    end

    // Effective radius r1*r2/(r1+r2) and its root.
    logic [RW-1:0]   reff;
    logic [SROW-1:0] sr;
    logic [KSW-1:0]  ks;

    hcf_div #(.NW(2 * RW), .DW(SW), .QW(RW)) u_div_reff (
        .i_clk, .i_num(rr), .i_den(s_pr), .o_quo(reff)
    );

    hcf_sqrt #(.IW(SRIW)) u_sqrt_reff (
        .i_clk, .i_x(SRIW'({reff, {F{1'b0}}})), .o_root(sr)
    );

    hcf_mul #(.AW(STIFF_W), .BW(SROW)) u_mul_ks (.i_clk, .i_a(r_stiff), .i_b(sr), .o_p(ks));

    // Distance.
    logic [DSTW-1:0]       center_dist;
    logic [SW+2*DXW-1:0]   sxy_d;
    logic [SW-1:0]         s_d;
    logic [DXW-1:0]        adx_d, ady_d;

    hcf_sqrt #(.IW(D2W)) u_sqrt_d2 (.i_clk, .i_x(r_d2), .o_root(center_dist));

    hcf_dly #(.W(SW + 2 * DXW), .L(T_DIST - T_S1)) u_dly_sxy (
        .i_clk, .i_d({r_s1, r_adx, r_ady}), .o_q(sxy_d)
    );

    assign {s_d, adx_d, ady_d} = sxy_d;

    logic [SW-1:0] r_pen;

    always_ff @(posedge i_clk) begin
        r_pen <= SW'(DSTW'(s_d) - center_dist);
    end

    // Unit normal magnitudes.
    logic [NQW-1:0] nxm, nym;

    hcf_div #(.NW(DXW + F), .DW(DSTW), .QW(NQW)) u_div_nx (
        .i_clk, .i_num({adx_d, {F{1'b0}}}), .i_den(center_dist), .o_quo(nxm)
    );

    hcf_div #(.NW(DXW + F), .DW(DSTW), .QW(NQW)) u_div_ny (
        .i_clk, .i_num({ady_d, {F{1'b0}}}), .i_den(center_dist), .o_quo(nym)
    );

    // Elastic part: stiffness * sqrt(reff) * pen^1.5.
    logic [SPOW-1:0] sp;
    logic [SW-1:0]   pen_sp;
    logic [PPW-1:0]  pp;
    logic [KSW-1:0]  ks_d;
    logic [EPW-1:0]  ep;
    logic [ELW-1:0]  el_sh;
    logic [FORCE_W-1:0] r_el;

    hcf_sqrt #(.IW(SPIW)) u_sqrt_pen (
        .i_clk, .i_x(SPIW'({r_pen, {F{1'b0}}})), .o_root(sp)
    );

    hcf_dly #(.W(SW), .L(T_SP - T_PEN)) u_dly_pen (.i_clk, .i_d(r_pen), .o_q(pen_sp));

    hcf_mul #(.AW(SW), .BW(SPOW)) u_mul_p15 (.i_clk, .i_a(pen_sp), .i_b(sp), .o_p(pp));

    hcf_dly #(.W(KSW), .L(T_P15 - T_KS)) u_dly_ks (.i_clk, .i_d(ks), .o_q(ks_d));

    hcf_mul #(.AW(KSW), .BW(P15W)) u_mul_el (
        .i_clk, .i_a(ks_d), .i_b(pp[PPW-1:F]), .o_p(ep)
    );

    assign el_sh = ep[EPW-1:F+GAIN_FRAC];

    always_ff @(posedge i_clk) begin
        r_el <= (el_sh > ELW'(FORCE_MAX)) ? FORCE_MAX : el_sh[FORCE_W-1:0];
    end

    // Damping on the approaching normal velocity.
    logic [2*DVW+1:0] dv_d;
    logic [DVW-1:0]   advx_d, advy_d;
    logic [1:0]       flip_d;
    logic [TW-1:0]    tx, ty;
    logic [DTW-1:0]   ex, ey;
    logic [DTW-1:0]   r_dot;

    hcf_dly #(.W(2 * DVW), .L(T_NRM - T_S1)) u_dly_dv (
        .i_clk, .i_d({r_advx, r_advy}), .o_q(dv_d[2*DVW-1:0])
    );

    hcf_dly #(.W(2), .L(T_DT - T_S1)) u_dly_flip (.i_clk, .i_d(r_flip), .o_q(flip_d));

    assign dv_d[2*DVW+1:2*DVW] = flip_d;
    assign {advx_d, advy_d}    = dv_d[2*DVW-1:0];

    hcf_mul #(.AW(DVW), .BW(NQW)) u_mul_tx (.i_clk, .i_a(advx_d), .i_b(nxm), .o_p(tx));
    hcf_mul #(.AW(DVW), .BW(NQW)) u_mul_ty (.i_clk, .i_a(advy_d), .i_b(nym), .o_p(ty));

    assign ex = dv_d[2*DVW+1] ? DTW'(~DTW'(tx) + 1'b1) : DTW'(tx);
    assign ey = dv_d[2*DVW]   ? DTW'(~DTW'(ty) + 1'b1) : DTW'(ty);

    always_ff @(posedge i_clk) begin
        r_dot <= ex + ey;
    end

    logic [DTW-1:0]     n_mag;
    logic [VSW-1:0]     vn_sh;
    logic [FORCE_W-1:0] r_vn;
    logic               r_neg;
    logic               neg_d;
    logic [DPW-1:0]     dp;
    logic [DSW-1:0]     dmp_sh;
    logic [FORCE_W-1:0] r_dmp;

    assign n_mag = ~r_dot + 1'b1;
    assign vn_sh = n_mag[DTW-1:F];

    always_ff @(posedge i_clk) begin
        r_vn  <= (vn_sh > VSW'(FORCE_MAX)) ? FORCE_MAX : vn_sh[FORCE_W-1:0];
        r_neg <= r_dot[DTW-1];
    end

    hcf_mul #(.AW(DAMP_W), .BW(FORCE_W)) u_mul_dmp (.i_clk, .i_a(r_damp), .i_b(r_vn), .o_p(dp));

    hcf_dly #(.W(1), .L(T_DPR - T_VN)) u_dly_neg (.i_clk, .i_d(r_neg), .o_q(neg_d));

    assign dmp_sh = dp[DPW-1:GAIN_FRAC];

    // Only an approaching pair gets the damping term.
    always_ff @(posedge i_clk) begin
        if (!neg_d) begin
            r_dmp <= '0;
        end else begin
            r_dmp <= (dmp_sh > DSW'(FORCE_MAX)) ? FORCE_MAX : dmp_sh[FORCE_W-1:0];
        end
    end

    // Total force magnitude.
    logic [FORCE_W-1:0] el_j, dmp_j;
    logic [FORCE_W:0]   n_fsum;
    logic [FORCE_W-1:0] r_fm;

    hcf_dly #(.W(FORCE_W), .L(T_JN - T_EL))  u_dly_el  (.i_clk, .i_d(r_el),  .o_q(el_j));
    hcf_dly #(.W(FORCE_W), .L(T_JN - T_DMP)) u_dly_dmp (.i_clk, .i_d(r_dmp), .o_q(dmp_j));

    assign n_fsum = (FORCE_W + 1)'(el_j) + (FORCE_W + 1)'(dmp_j);

    always_ff @(posedge i_clk) begin
        r_fm <= n_fsum[FORCE_W] ? FORCE_MAX : n_fsum[FORCE_W-1:0];
    end

    // Force components along the normal.
    logic [2*NQW-1:0]   nxy_fm, nxy_fp;
    logic [FPW-1:0]     fpx, fpy;
    logic [FORCE_W-1:0] fm_fp;
    logic [SW-1:0]      pen_fp;
    logic [1:0]         sgn_fp;
    logic               con_fp;

    hcf_dly #(.W(2 * NQW), .L(T_FM - T_NRM)) u_dly_nfm (
        .i_clk, .i_d({nxm, nym}), .o_q(nxy_fm)
    );
    hcf_dly #(.W(2 * NQW), .L(T_FP - T_FM)) u_dly_nfp (.i_clk, .i_d(nxy_fm), .o_q(nxy_fp));

    hcf_mul #(.AW(FORCE_W), .BW(NQW)) u_mul_fx (
        .i_clk, .i_a(r_fm), .i_b(nxy_fm[2*NQW-1:NQW]), .o_p(fpx)
    );
    hcf_mul #(.AW(FORCE_W), .BW(NQW)) u_mul_fy (
        .i_clk, .i_a(r_fm), .i_b(nxy_fm[NQW-1:0]), .o_p(fpy)
    );

    hcf_dly #(.W(FORCE_W), .L(T_FP - T_FM))  u_dly_fm  (.i_clk, .i_d(r_fm),   .o_q(fm_fp));
    hcf_dly #(.W(SW),      .L(T_FP - T_SP))  u_dly_pfp (.i_clk, .i_d(pen_sp), .o_q(pen_fp));
    hcf_dly #(.W(2),       .L(T_FP - T_S1))  u_dly_sgn (.i_clk, .i_d(r_sgn),  .o_q(sgn_fp));
    hcf_dly #(.W(1),       .L(T_FP - T_D2))  u_dly_con (.i_clk, .i_d(r_con),  .o_q(con_fp));

    logic [OFW-1:0] fvx, fvy;
    logic [NMW-1:0] nvx, nvy;

    assign fvx = fpx[FPW-1:F];
    assign fvy = fpy[FPW-1:F];
    assign nvx = NMW'(nxy_fp[2*NQW-1:NQW]);
    assign nvy = NMW'(nxy_fp[NQW-1:0]);

    // Output registers; a pair without contact reports all zeros.
    logic               r_o_con;
    logic [OFW-1:0]     r_o_fx, r_o_fy;
    logic [SW-1:0]      r_o_pen;
    logic [NMW-1:0]     r_o_nx, r_o_ny;
    logic [FORCE_W-1:0] r_o_imp;

    always_ff @(posedge i_clk) begin
        if (!con_fp) begin
            r_o_con <= 1'b0;
            r_o_fx  <= '0;
            r_o_fy  <= '0;
            r_o_pen <= '0;
            r_o_nx  <= '0;
            r_o_ny  <= '0;
            r_o_imp <= '0;
        end else begin
            r_o_con <= 1'b1;
            r_o_fx  <= sgn_fp[1] ? OFW'(~fvx + 1'b1) : fvx;
            r_o_fy  <= sgn_fp[0] ? OFW'(~fvy + 1'b1) : fvy;
            r_o_pen <= pen_fp;
            r_o_nx  <= sgn_fp[1] ? NMW'(~nvx + 1'b1) : nvx;
            r_o_ny  <= sgn_fp[0] ? NMW'(~nvy + 1'b1) : nvy;
            r_o_imp <= fm_fp;
        end
    end

    assign o_valid        = r_vld[T_OUT];
    assign o_in_contact   = r_o_con;
    assign o_force_x      = r_o_fx;
    assign o_force_y      = r_o_fy;
    assign o_penetration  = r_o_pen;
    assign o_normal_x     = r_o_nx;
    assign o_normal_y     = r_o_ny;
    assign o_impulse_size = r_o_imp;

endmodule
